FILE: hdl/png_scanline_unfilter_core_assert.svh
// Assertion macros shared by the checker of the scanline unfilter core.
// Each macro expects signals named clk and rst_n in the scope that uses it.
`ifndef PNG_SCANLINE_UNFILTER_CORE_ASSERT_SVH
`define PNG_SCANLINE_UNFILTER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PSU_ASSERT_HOLDS(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PSU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/psu_pkg.sv
// Package of the PNG scanline unfilter core: widths, codes and the queue word.
// Used by the interfaces and by every module of the core; depends on nothing.
package psu_pkg;

    localparam int DATA_W      = 8;
    localparam int WIDTH_W     = 13;
    localparam int HEIGHT_W    = 16;
    localparam int CH_W        = 3;
    localparam int BPC_W       = 2;
    localparam int BPP_W       = 4;
    localparam int LEN_W       = 16;
    localparam int IDX_W       = 15;
    localparam int SLOT_W      = 3;
    localparam int NUM_SLOTS   = 8;
    localparam int LINE_DEPTH  = 32768;
    localparam int MAX_WIDTH   = 4096;
    localparam int MAX_CH      = 4;
    localparam int MAX_BPC     = 2;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = 2;
    localparam int FIFO_CW     = 3;
    localparam int ADDR_W      = 4;
    localparam int PDATA_W     = 32;

    typedef enum logic [2:0] {
        FILT_NONE,
        FILT_SUB,
        FILT_UP,
        FILT_AVG,
        FILT_PAETH
    } psu_filter_t;

    typedef enum logic [1:0] {
        REG_WIDTH,
        REG_HEIGHT,
        REG_CHANNELS,
        REG_BPC
    } psu_reg_t;

    typedef struct packed {
        logic [WIDTH_W-1:0]  width_pixels;
        logic [HEIGHT_W-1:0] height_rows;
        logic [CH_W-1:0]     channels;
        logic [BPC_W-1:0]    bytes_per_channel;
    } psu_cfg_t;

    typedef struct packed {
        logic is_error;
        logic [DATA_W-1:0] data;
        psu_filter_t       filt;
        logic [IDX_W-1:0]  idx;
        logic [SLOT_W-1:0] slot;
        logic top_row;
        logic row_open;
        logic emit;
        logic last_row;
        logic last_img;
    } psu_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } psu_fifo_stat_t;

endpackage

FILE: hdl/psu_if.sv
// Handshake channels of the scanline unfilter core: input bytes and results.
// Depends on psu_pkg for the field widths.
interface psu_in_if
    import psu_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] data_byte;
    logic              image_start;

    modport source (output valid, output data_byte, output image_start, input ready);
    modport sink (input valid, input data_byte, input image_start, output ready);
endinterface

interface psu_out_if
    import psu_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] channel_value;
    logic              last_in_row;
    logic              last_in_image;
    logic              error_code;

    modport source (output valid, output channel_value, output last_in_row,
                    output last_in_image, output error_code, input ready);
    modport sink (input valid, input channel_value, input last_in_row,
                  input last_in_image, input error_code, output ready);
endinterface

FILE: hdl/psu_front.sv
// Front end: accepts bytes, tracks row and image position, classifies each
// byte and pushes work words to the queue. Depends on psu_pkg and psu_if.
module psu_front
    import psu_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    psu_in_if.sink         data_ch,
    input  psu_cfg_t       cfg,
    input  psu_fifo_stat_t fifo_stat,
    output logic           push,
    output psu_item_t      push_item
);

    logic [IDX_W-1:0]    bir_reg, bir_next;
    logic [1:0]          mod3_reg, mod3_next;
    logic [HEIGHT_W-1:0] row_reg, row_next;
    psu_filter_t         filt_reg, filt_next;
    logic                await_reg, await_next;
    logic                first_reg, first_next;
    logic                halt_reg, halt_next;
    logic                fresh_reg, fresh_next;

    logic [WIDTH_W-1:0]  w_eff;
    logic [HEIGHT_W-1:0] h_eff;
    logic [CH_W-1:0]     ch_eff;
    logic [BPC_W-1:0]    bpc_eff;
    logic [BPP_W-1:0]    bpp;
    logic [LEN_W-1:0]    rowlen;

    logic [IDX_W-1:0]    cur_bir;
    logic [1:0]          cur_mod3;
    logic [HEIGHT_W-1:0] cur_row;
    logic                cur_await;
    logic                cur_first;
    logic                cur_halt;
    logic                fire;
    logic [SLOT_W-1:0]   slot;
    logic [LEN_W-1:0]    idx_ext;
    logic [HEIGHT_W:0]   row_inc;
    logic                row_end;

    assign data_ch.ready = !fifo_stat.full;
    assign fire = data_ch.valid && data_ch.ready;

    always_comb
    begin
        if (cfg.width_pixels == '0)
            w_eff = WIDTH_W'(1);
        else if (cfg.width_pixels > WIDTH_W'(MAX_WIDTH))
            w_eff = WIDTH_W'(MAX_WIDTH);
        else
            w_eff = cfg.width_pixels;
        h_eff = (cfg.height_rows == '0) ? HEIGHT_W'(1) : cfg.height_rows;
        if (cfg.channels == '0)
            ch_eff = CH_W'(1);
        else if (cfg.channels > CH_W'(MAX_CH))
            ch_eff = CH_W'(MAX_CH);
        else
            ch_eff = cfg.channels;
        if (cfg.bytes_per_channel == '0)
            bpc_eff = BPC_W'(1);
        else if (cfg.bytes_per_channel > BPC_W'(MAX_BPC))
            bpc_eff = BPC_W'(MAX_BPC);
        else
            bpc_eff = cfg.bytes_per_channel;
        bpp = BPP_W'({1'b0, ch_eff} * {2'b00, bpc_eff});
        rowlen = {{(LEN_W-WIDTH_W){1'b0}}, w_eff} * {{(LEN_W-BPP_W){1'b0}}, bpp};
    end

    always_comb
    begin
        cur_bir   = data_ch.image_start ? '0 : bir_reg;
        cur_mod3  = data_ch.image_start ? '0 : mod3_reg;
        cur_row   = data_ch.image_start ? '0 : row_reg;
        cur_await = data_ch.image_start ? 1'b1 : await_reg;
        cur_first = data_ch.image_start ? 1'b1 : first_reg;
        cur_halt  = data_ch.image_start ? 1'b0 : halt_reg;

        case (bpp)
            BPP_W'(2): slot = {2'b00, cur_bir[0]};
            BPP_W'(3): slot = {1'b0, cur_mod3};
            BPP_W'(4): slot = {1'b0, cur_bir[1:0]};
            BPP_W'(6): slot = (cur_mod3[0] != cur_bir[0]) ? ({1'b0, cur_mod3} + SLOT_W'(3))
                                                            : {1'b0, cur_mod3};
            BPP_W'(8): slot = cur_bir[2:0];
            default:   slot = '0;
        endcase

        idx_ext = {1'b0, cur_bir};
        row_inc = {1'b0, cur_row} + (HEIGHT_W+1)'(1);
        row_end = (idx_ext + LEN_W'(1)) >= rowlen;

        push_item.is_error = 1'b0;
        push_item.data     = data_ch.data_byte;
        push_item.filt     = filt_reg;
        push_item.idx      = cur_bir;
        push_item.slot     = slot;
        push_item.top_row  = cur_first;
        push_item.row_open = fresh_reg;
        push_item.emit     = (bpc_eff == BPC_W'(1)) || !cur_bir[0];
        push_item.last_row = (idx_ext + {{(LEN_W-BPC_W){1'b0}}, bpc_eff}) >= rowlen;
        push_item.last_img = push_item.last_row && (row_inc >= {1'b0, h_eff});

        push       = 1'b0;
        bir_next   = bir_reg;
        mod3_next  = mod3_reg;
        row_next   = row_reg;
        filt_next  = filt_reg;
        await_next = await_reg;
        first_next = first_reg;
        halt_next  = halt_reg;
        fresh_next = fresh_reg;

        if (fire)
        begin
            bir_next   = cur_bir;
            mod3_next  = cur_mod3;
            row_next   = cur_row;
            await_next = cur_await;
            first_next = cur_first;
            halt_next  = cur_halt;
            if (cur_halt)
            begin
                push = 1'b0;
            end
            else if (cur_await)
            begin
                if (data_ch.data_byte > {5'b00000, FILT_PAETH})
                begin
                    push               = 1'b1;
                    push_item.is_error = 1'b1;
                    push_item.emit     = 1'b1;
                    push_item.last_row = 1'b0;
                    push_item.last_img = 1'b0;
                    halt_next          = 1'b1;
                end
                else
                begin
                    filt_next  = psu_filter_t'(data_ch.data_byte[2:0]);
                    await_next = 1'b0;
                    bir_next   = '0;
                    mod3_next  = '0;
                    fresh_next = 1'b1;
                end
            end
            else
            begin
                push       = 1'b1;
                fresh_next = 1'b0;
                if (row_end)
                begin
                    bir_next   = '0;
                    mod3_next  = '0;
                    await_next = 1'b1;
                    first_next = 1'b0;
                    row_next   = row_inc[HEIGHT_W-1:0];
                    if (row_inc[HEIGHT_W-1:0] == '0 || row_inc[HEIGHT_W-1:0] >= h_eff)
                    begin
                        row_next   = '0;
                        first_next = 1'b1;
                    end
                end
                else
                begin
                    bir_next  = cur_bir + IDX_W'(1);
                    mod3_next = (cur_mod3 == 2'd2) ? 2'd0 : cur_mod3 + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bir_reg   <= '0;
            mod3_reg  <= '0;
            row_reg   <= '0;
            filt_reg  <= FILT_NONE;
            await_reg <= 1'b1;
            first_reg <= 1'b1;
            halt_reg  <= 1'b0;
            fresh_reg <= 1'b0;
        end
        else
        begin
            bir_reg   <= bir_next;
            mod3_reg  <= mod3_next;
            row_reg   <= row_next;
            filt_reg  <= filt_next;
            await_reg <= await_next;
            first_reg <= first_next;
            halt_reg  <= halt_next;
            fresh_reg <= fresh_next;
        end
    end

endmodule

FILE: hdl/psu_fifo.sv
// Short queue of work words between the front end and the back end.
// Depends on psu_pkg for the word type and depth.
module psu_fifo
    import psu_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  psu_item_t      push_item,
    input  logic           pop,
    output psu_item_t      head_item,
    output psu_fifo_stat_t stat
);

    psu_item_t            slot_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_reg, wr_next;
    logic [FIFO_AW-1:0]   rd_reg, rd_next;
    logic [FIFO_CW-1:0]   count_reg, count_next;

    assign head_item  = slot_reg[rd_reg];
    assign stat.full  = (count_reg == FIFO_CW'(FIFO_DEPTH));
    assign stat.empty = (count_reg == '0);

    always_comb
    begin
        wr_next    = push ? wr_reg + FIFO_AW'(1) : wr_reg;
        rd_next    = pop ? rd_reg + FIFO_AW'(1) : rd_reg;
        count_next = count_reg + FIFO_CW'(push) - FIFO_CW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

endmodule

FILE: hdl/psu_back.sv
// Back end: reads the line buffer, reconstructs each byte from its filter
// and neighbors, and holds the result word. Depends on psu_pkg and psu_if.
module psu_back
    import psu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      fifo_empty,
    input  psu_item_t head_item,
    output logic      pop,
    psu_out_if.source result_ch
);

    logic [DATA_W-1:0] line_mem [LINE_DEPTH];
    logic [DATA_W-1:0] left_reg [NUM_SLOTS];
    logic [DATA_W-1:0] ul_reg [NUM_SLOTS];

    logic              s1_valid_reg, s1_valid_next;
    psu_item_t         s1_reg;
    logic [DATA_W-1:0] rd_reg;
    logic              byp_reg;
    logic [DATA_W-1:0] byp_data_reg;

    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] value_reg;
    logic              last_row_reg;
    logic              last_img_reg;
    logic              error_reg;

    logic              out_free;
    logic              s1_adv;
    logic              sample;
    logic [DATA_W-1:0] a, b, c, pred, x;
    logic [DATA_W-1:0] pa, pb;
    logic [DATA_W:0]   sum_ab, two_c, pc;
    logic [DATA_W:0]   avg_sum;

    assign out_free = !out_valid_reg || result_ch.ready;
    assign s1_adv   = s1_valid_reg && (!s1_reg.emit || out_free);
    assign pop      = !fifo_empty && (!s1_valid_reg || s1_adv);
    assign sample   = !s1_reg.is_error;

    always_comb
    begin
        a = s1_reg.row_open ? '0 : left_reg[s1_reg.slot];
        c = s1_reg.row_open ? '0 : ul_reg[s1_reg.slot];
        if (s1_reg.top_row)
            b = '0;
        else if (byp_reg)
            b = byp_data_reg;
        else
            b = rd_reg;

        pa      = (b >= c) ? b - c : c - b;
        pb      = (a >= c) ? a - c : c - a;
        sum_ab  = {1'b0, a} + {1'b0, b};
        two_c   = {c, 1'b0};
        pc      = (sum_ab >= two_c) ? sum_ab - two_c : two_c - sum_ab;
        avg_sum = {1'b0, a} + {1'b0, b};

        case (s1_reg.filt)
            FILT_SUB:   pred = a;
            FILT_UP:    pred = b;
            FILT_AVG:   pred = avg_sum[DATA_W:1];
            FILT_PAETH:
            begin
                if (pa <= pb && {1'b0, pa} <= pc)
                    pred = a;
                else if ({1'b0, pb} <= pc)
                    pred = b;
                else
                    pred = c;
            end
            default:    pred = '0;
        endcase
        x = s1_reg.data + pred;

        s1_valid_next = pop ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);

        if (s1_adv && s1_reg.emit)
            out_valid_next = 1'b1;
        else if (result_ch.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // The line buffer is read as a word leaves the queue. When the word ahead
    // writes the same entry at that edge, its value is forwarded instead.
    always_ff @(posedge clk)
    begin
        if (s1_adv && sample)
            line_mem[s1_reg.idx] <= x;
        if (pop)
        begin
            rd_reg       <= line_mem[head_item.idx];
            s1_reg       <= head_item;
            byp_reg      <= s1_adv && sample && (s1_reg.idx == head_item.idx);
            byp_data_reg <= x;
        end
        if (s1_adv && s1_reg.emit)
        begin
            value_reg    <= s1_reg.is_error ? '0 : x;
            last_row_reg <= s1_reg.last_row;
            last_img_reg <= s1_reg.last_img;
            error_reg    <= s1_reg.is_error;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int j = 0; j < NUM_SLOTS; j++)
            begin
                left_reg[j] <= '0;
                ul_reg[j]   <= '0;
            end
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_adv && sample)
            begin
                for (int j = 0; j < NUM_SLOTS; j++)
                begin
                    if (SLOT_W'(j) == s1_reg.slot)
                    begin
                        left_reg[j] <= x;
                        ul_reg[j]   <= b;
                    end
                    else if (s1_reg.row_open)
                    begin
                        left_reg[j] <= '0;
                        ul_reg[j]   <= '0;
                    end
                end
            end
        end
    end

    assign result_ch.valid         = out_valid_reg;
    assign result_ch.channel_value = value_reg;
    assign result_ch.last_in_row   = last_row_reg;
    assign result_ch.last_in_image = last_img_reg;
    assign result_ch.error_code    = error_reg;

endmodule

FILE: hdl/png_scanline_unfilter_core.sv
// A sample byte's word passes the queue, the stage-one register and the output register.
// Throughput: one byte per cycle while results are taken, set by the line buffer's one read
// and one write per cycle. The input is held off only while the four-word queue is full.
// Reset clears counters, flags and neighbor bytes; the line buffer is not cleared,
// since the first row of every image takes the row above as zero.
module png_scanline_unfilter_core
    import psu_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    psu_in_if.sink             data_ch,
    psu_out_if.source          result_ch,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    psu_cfg_t       cfg_reg;
    psu_fifo_stat_t fifo_stat;
    psu_item_t      push_item;
    psu_item_t      head_item;
    logic           push;
    logic           pop;
    psu_reg_t       reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = psu_reg_t'(paddr[3:2]);

    always_comb
    begin
        case (reg_sel)
            REG_WIDTH:    prdata = {{(PDATA_W-WIDTH_W){1'b0}}, cfg_reg.width_pixels};
            REG_HEIGHT:   prdata = {{(PDATA_W-HEIGHT_W){1'b0}}, cfg_reg.height_rows};
            REG_CHANNELS: prdata = {{(PDATA_W-CH_W){1'b0}}, cfg_reg.channels};
            REG_BPC:      prdata = {{(PDATA_W-BPC_W){1'b0}}, cfg_reg.bytes_per_channel};
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.width_pixels      <= WIDTH_W'(1);
            cfg_reg.height_rows       <= HEIGHT_W'(1);
            cfg_reg.channels          <= CH_W'(1);
            cfg_reg.bytes_per_channel <= BPC_W'(1);
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (reg_sel)
                REG_WIDTH:    cfg_reg.width_pixels      <= pwdata[WIDTH_W-1:0];
                REG_HEIGHT:   cfg_reg.height_rows       <= pwdata[HEIGHT_W-1:0];
                REG_CHANNELS: cfg_reg.channels          <= pwdata[CH_W-1:0];
                REG_BPC:      cfg_reg.bytes_per_channel <= pwdata[BPC_W-1:0];
                default:      cfg_reg <= cfg_reg;
            endcase
        end
    end

    psu_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .data_ch   (data_ch),
        .cfg       (cfg_reg),
        .fifo_stat (fifo_stat),
        .push      (push),
        .push_item (push_item)
    );

    psu_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .stat      (fifo_stat)
    );

    psu_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .fifo_empty (fifo_stat.empty),
        .head_item  (head_item),
        .pop        (pop),
        .result_ch  (result_ch)
    );

endmodule

FILE: hdl/psu_checker.sv
// Port-level checker of the scanline unfilter core and its bind statement.
// Depends on psu_pkg and on the macros in png_scanline_unfilter_core_assert.svh.
`include "png_scanline_unfilter_core_assert.svh"

module psu_checker
    import psu_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_ready,
    input logic [DATA_W-1:0] channel_value,
    input logic              last_in_row,
    input logic              last_in_image,
    input logic              error_code
);

    `PSU_ASSERT_NEXT(a_valid_hold, out_valid && !out_ready, out_valid, "result word withdrawn")
    `PSU_ASSERT_NEXT(a_word_hold, out_valid && !out_ready, $stable(channel_value) && $stable(last_in_row) && $stable(last_in_image) && $stable(error_code), "stalled word changed")
    `PSU_ASSERT_HOLDS(a_error_word, out_valid && error_code, channel_value == '0 && !last_in_row && !last_in_image, "error word carries data")
    `PSU_ASSERT_HOLDS(a_image_end, out_valid && last_in_image, last_in_row, "image ends inside a row")

endmodule

bind png_scanline_unfilter_core psu_checker u_psu_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (result_ch.valid),
    .out_ready     (result_ch.ready),
    .channel_value (result_ch.channel_value),
    .last_in_row   (result_ch.last_in_row),
    .last_in_image (result_ch.last_in_image),
    .error_code    (result_ch.error_code)
);
